// ===== src/isc_pkg.sv =====
`timescale 1ns / 1ps

package isc_pkg;

    // Field widths of the stream payloads.
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 3;
    localparam int IDX_W      = 10;
    localparam int STATUS_W   = 3;
    localparam int DEPTH_W    = 11;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    // Operation codes carried in the input tuser.
    typedef enum logic [KIND_W-1:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_PEEK_BOTTOM = 3'd2,
        OP_PEEK_TOP    = 3'd3,
        OP_ADD         = 3'd4,
        OP_SUB         = 3'd5,
        OP_MUL         = 3'd6,
        OP_DIV         = 3'd7
    } t_op;

    // Result status codes carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FEW     = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDATA,
        S_OPB,
        S_OPA,
        S_ALU,
        S_DIV,
        S_FINISH
    } t_state;

    // Stack read address source.
    typedef enum logic [1:0] {
        RD_TOP,
        RD_NEXT,
        RD_BOTTOM,
        RD_FROM_TOP
    } t_rd_sel;

    // Stack write data source.
    typedef enum logic [1:0] {
        WR_PUSH,
        WR_ALU,
        WR_DIV
    } t_wr_sel;

    // Entry count update.
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_DEC2
    } t_cnt_op;

    // Result value source.
    typedef enum logic [1:0] {
        VAL_ZERO,
        VAL_RDATA,
        VAL_ALU,
        VAL_DIV
    } t_val_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_cnt_op  cnt_op;
        logic     val_en;
        t_val_sel val_sel;
        logic     status_en;
        t_status  status;
        logic     cap_a;
        logic     cap_b;
        logic     div_start;
        logic     out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic idx_ok;
        logic few;
        logic b_zero;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/integer_stack_calculator_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata: push_value[31:0], peek_index[41:32]; tuser: kind[2:0]
// m_axis    out        tdata: result_value[31:0], depth_now[42:32]; tuser: status[2:0]
//
// One operation is worked at a time; the input is ready again once its result
// is in the output register. Pop and peek read the stack once; add, subtract,
// multiply and divide read it twice, and floor divide then waits on the
// one-bit-per-cycle divider. Push and the errors found at decode do not read
// the single-port stack at all.
// Reset empties the stack at once; stored words need no clearing.
// A stalled output holds the next operation in its final state until taken.

module integer_stack_calculator_core
    import isc_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // push_value[31:0], peek_index[41:32]
    input  logic [KIND_W-1:0]    i_s_axis_tuser,  // kind[2:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // result_value[31:0], depth_now[42:32]
    output logic [STATUS_W-1:0]  o_m_axis_tuser   // status[2:0]
);

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [DATA_W-1:0]    result_value;
    logic [DEPTH_W-1:0]   depth_now;

    isc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    isc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_s_axis_tuser),
        .i_push_value   (i_s_axis_tdata[DATA_W-1:0]),
        .i_peek_index   (i_s_axis_tdata[DATA_W+IDX_W-1:DATA_W]),
        .i_m_ready      (i_m_axis_tready),
        .o_m_valid      (o_m_axis_tvalid),
        .o_result_value (result_value),
        .o_status       (o_m_axis_tuser),
        .o_depth_now    (depth_now)
    );

    // Pack the result fields, padded to whole bytes.
    assign o_m_axis_tdata = {{(M_TDATA_W - DATA_W - DEPTH_W){1'b0}}, depth_now, result_value};

endmodule

// ===== src/isc_ram.sv =====
`timescale 1ns / 1ps

module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/isc_div.sv =====
`timescale 1ns / 1ps

module isc_div
    import isc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_fix;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic [DATA_W:0]   n_shift;
    logic [DATA_W:0]   n_diff;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign n_shift = {r_rem, r_quo[DATA_W-1]};
    assign n_diff  = n_shift - {1'b0, r_den};

    // Control flags of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(DATA_W - 1)) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Magnitude division, then the floor correction for differing signs.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[DATA_W-1] ? -i_dividend : i_dividend;
            r_den <= i_divisor[DATA_W-1] ? -i_divisor : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (!n_diff[DATA_W]) begin
                r_rem <= n_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end else if (r_fix && r_neg) begin
            // A negative inexact quotient rounds down: -q - 1 is ~q.
            r_quo <= (r_rem != '0) ? ~r_quo : -r_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== src/isc_datapath.sv =====
`timescale 1ns / 1ps

module isc_datapath
    import isc_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic [IDX_W-1:0]    i_peek_index,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [DEPTH_W-1:0]  o_depth_now
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    t_op               r_op;
    logic [DATA_W-1:0] r_push;
    logic [IDX_W-1:0]  r_idx;
    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_value;
    t_status           r_status;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_status           r_out_status;
    logic [CW-1:0]     r_out_count;

    logic [AW-1:0]     n_rd_addr;
    logic [DATA_W-1:0] n_wr_data;
    logic [DATA_W-1:0] n_alu;
    logic [DATA_W-1:0] rd_data;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;

    // Operation capture on an input transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_kind);
            r_push <= i_push_value;
            r_idx  <= i_peek_index;
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_cmd.cnt_op)
                CNT_HOLD: r_count <= r_count;
                CNT_INC:  r_count <= r_count + CW'(1);
                CNT_DEC:  r_count <= r_count - CW'(1);
                CNT_DEC2: r_count <= r_count - CW'(2);
            endcase
        end
    end

    // Stack read address.
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_TOP:      n_rd_addr = AW'(r_count - CW'(1));
            RD_NEXT:     n_rd_addr = AW'(r_count - CW'(2));
            RD_BOTTOM:   n_rd_addr = AW'(r_idx);
            RD_FROM_TOP: n_rd_addr = AW'(XW'(r_count) - XW'(r_idx) - XW'(1));
        endcase
    end

    // Add, subtract and low word of the product, all with 32-bit wrap.
    always_comb begin
        unique case (r_op)
            OP_ADD:  n_alu = r_a + r_b;
            OP_SUB:  n_alu = r_a - r_b;
            OP_MUL:  n_alu = r_a * r_b;
            default: n_alu = '0;
        endcase
    end

    // Stack write data.
    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_PUSH: n_wr_data = r_push;
            WR_ALU:  n_wr_data = n_alu;
            WR_DIV:  n_wr_data = div_quot;
            default: n_wr_data = r_push;
        endcase
    end

    isc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (AW'(r_count)),
        .i_wr_data (n_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (rd_data)
    );

    isc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (rd_data),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Operands, result value and status of the item at work.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_b) begin
            r_b <= rd_data;
        end
        if (i_cmd.cap_a) begin
            r_a <= rd_data;
        end
        if (i_cmd.val_en) begin
            unique case (i_cmd.val_sel)
                VAL_ZERO:  r_value <= '0;
                VAL_RDATA: r_value <= rd_data;
                VAL_ALU:   r_value <= n_alu;
                VAL_DIV:   r_value <= div_quot;
            endcase
        end
        if (i_cmd.status_en) begin
            r_status <= i_cmd.status;
        end
    end

    // Output register, so a finished result waits apart from the work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= r_value;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    // Status toward the controller.
    assign o_sts.op       = r_op;
    assign o_sts.full     = (r_count == CW'(STACK_DEPTH));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.idx_ok   = (XW'(r_idx) < XW'(r_count));
    assign o_sts.few      = (r_count < CW'(2));
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_m_ready;

    assign o_m_valid      = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_depth_now    = DEPTH_W'(r_out_count);

endmodule

// ===== src/isc_ctrl.sv =====
`timescale 1ns / 1ps

module isc_ctrl
    import isc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state         = r_state;
        o_s_ready       = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.rd_sel    = RD_TOP;
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_sel    = WR_PUSH;
        o_cmd.cnt_op    = CNT_HOLD;
        o_cmd.val_en    = 1'b0;
        o_cmd.val_sel   = VAL_ZERO;
        o_cmd.status_en = 1'b0;
        o_cmd.status    = ST_OK;
        o_cmd.cap_a     = 1'b0;
        o_cmd.cap_b     = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.out_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                // Every item starts from a zero value and, unless decode finds an error, an ok status.
                o_cmd.val_en    = 1'b1;
                o_cmd.val_sel   = VAL_ZERO;
                o_cmd.status_en = 1'b1;
                o_cmd.status    = ST_OK;
                unique case (i_sts.op)
                    OP_PUSH: begin
                        n_state = S_FINISH;
                        if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_PUSH;
                            o_cmd.cnt_op = CNT_INC;
                        end
                    end
                    OP_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.status = ST_EMPTY;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            o_cmd.cnt_op = CNT_DEC;
                            n_state      = S_RDATA;
                        end
                    end
                    OP_PEEK_BOTTOM, OP_PEEK_TOP: begin
                        if (!i_sts.idx_ok) begin
                            o_cmd.status = ST_RANGE;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = (i_sts.op == OP_PEEK_TOP) ? RD_FROM_TOP
                                                                     : RD_BOTTOM;
                            n_state      = S_RDATA;
                        end
                    end
                    default: begin
                        if (i_sts.few) begin
                            o_cmd.status = ST_FEW;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            n_state      = S_OPB;
                        end
                    end
                endcase
            end
            S_RDATA: begin
                o_cmd.val_en  = 1'b1;
                o_cmd.val_sel = VAL_RDATA;
                n_state       = S_FINISH;
            end
            S_OPB: begin
                // Top entry arrives; fetch the one below it.
                o_cmd.cap_b  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
                n_state      = S_OPA;
            end
            S_OPA: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.cnt_op = CNT_DEC2;
                if (i_sts.op != OP_DIV) begin
                    n_state = S_ALU;
                end else if (i_sts.b_zero) begin
                    // Both operands are gone and nothing goes back.
                    o_cmd.status_en = 1'b1;
                    o_cmd.status    = ST_DIVZERO;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_ALU: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_ALU;
                o_cmd.val_en  = 1'b1;
                o_cmd.val_sel = VAL_ALU;
                o_cmd.cnt_op  = CNT_INC;
                n_state       = S_FINISH;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_DIV;
                    o_cmd.val_en  = 1'b1;
                    o_cmd.val_sel = VAL_DIV;
                    o_cmd.cnt_op  = CNT_INC;
                    n_state       = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== src/isc_checker.sv =====
`timescale 1ns / 1ps

module isc_checker
    import isc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input logic [KIND_W-1:0]    i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [STATUS_W-1:0]  o_m_axis_tuser
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed or dropped while stalled");

    // Only one operation is in work: accepting one closes the input.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after a transaction");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= ST_FULL)
        else $error("undefined status code");

    // Every error reports a zero value.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK |-> o_m_axis_tdata[DATA_W-1:0] == '0)
        else $error("nonzero value on an error result");

endmodule

bind integer_stack_calculator_core isc_checker u_isc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== test/integer_stack_calculator_core_tb.sv =====
`timescale 1ns / 1ps

module integer_stack_calculator_core_tb;
    import isc_pkg::*;

    localparam int STACK_WORDS   = 1024;
    localparam int MAX_WAIT      = 18;
    // Longest operation is a floor divide; allow a margin.
    localparam int SETTLE_CYCLES = 60;
    localparam int MIXED_ITEMS   = 120;
    localparam int FULL_ITEMS    = 60;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [DATA_W-1:0]  value;
        t_status            status;
        logic [DEPTH_W-1:0] depth;
    } t_calc_result;

    // One row of the directed stimulus table.
    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        logic              has_want;
        t_calc_result      want;
    } t_plan_row;

    localparam int DIRECTED_ROWS = 24;

    // Rows with has_want set carry a hand-written result; the rest are predicted.
    localparam t_plan_row DIRECTED [DIRECTED_ROWS] = '{
        // Errors on the empty stack right after reset.
        '{OP_POP,         32'h0000_0000, 10'd0,    1'b1, '{32'h0000_0000, ST_EMPTY,   11'd0}},
        '{OP_PEEK_BOTTOM, 32'h0000_0000, 10'd0,    1'b1, '{32'h0000_0000, ST_RANGE,   11'd0}},
        '{OP_PEEK_TOP,    32'hFFFF_FFFF, 10'd1023, 1'b1, '{32'h0000_0000, ST_RANGE,   11'd0}},
        '{OP_ADD,         32'h0000_0000, 10'd0,    1'b1, '{32'h0000_0000, ST_FEW,     11'd0}},
        // Largest positive word plus one wraps to the most negative word.
        '{OP_PUSH,        32'h7FFF_FFFF, 10'd0,    1'b1, '{32'h0000_0000, ST_OK,      11'd1}},
        '{OP_DIV,         32'h0000_0000, 10'd0,    1'b1, '{32'h0000_0000, ST_FEW,     11'd1}},
        '{OP_PUSH,        32'h0000_0001, 10'd0,    1'b1, '{32'h0000_0000, ST_OK,      11'd2}},
        '{OP_ADD,         32'h0000_0000, 10'd0,    1'b1, '{32'h8000_0000, ST_OK,      11'd1}},
        // Most negative word divided by minus one overflows back to itself.
        '{OP_PUSH,        32'hFFFF_FFFF, 10'd0,    1'b1, '{32'h0000_0000, ST_OK,      11'd2}},
        '{OP_DIV,         32'h0000_0000, 10'd0,    1'b1, '{32'h8000_0000, ST_OK,      11'd1}},
        '{OP_PEEK_TOP,    32'h0000_0000, 10'd0,    1'b1, '{32'h8000_0000, ST_OK,      11'd1}},
        '{OP_PEEK_BOTTOM, 32'h0000_0000, 10'd1,    1'b1, '{32'h0000_0000, ST_RANGE,   11'd1}},
        // Divide by zero consumes both operands and pushes nothing.
        '{OP_PUSH,        32'h0000_0000, 10'd0,    1'b1, '{32'h0000_0000, ST_OK,      11'd2}},
        '{OP_DIV,         32'h0000_0000, 10'd0,    1'b1, '{32'h0000_0000, ST_DIVZERO, 11'd0}},
        // Floor division with mixed signs, subtract and multiply wrap.
        '{OP_PUSH,        32'hFFFF_FFF9, 10'd0,    1'b0, '0},
        '{OP_PUSH,        32'h0000_0002, 10'd0,    1'b0, '0},
        '{OP_DIV,         32'h0000_0000, 10'd0,    1'b0, '0},
        '{OP_PUSH,        32'h0000_0003, 10'd0,    1'b0, '0},
        '{OP_SUB,         32'h0000_0000, 10'd0,    1'b0, '0},
        '{OP_PUSH,        32'h8000_0001, 10'd0,    1'b0, '0},
        '{OP_MUL,         32'h0000_0000, 10'd0,    1'b0, '0},
        '{OP_PEEK_BOTTOM, 32'h0000_0000, 10'd0,    1'b0, '0},
        '{OP_POP,         32'h0000_0000, 10'd0,    1'b0, '0},
        '{OP_POP,         32'h0000_0000, 10'd0,    1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;   // push_value[31:0], peek_index[41:32]
    logic [KIND_W-1:0]    i_s_axis_tuser;   // kind[2:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;   // result_value[31:0], depth_now[42:32]
    logic [STATUS_W-1:0]  o_m_axis_tuser;   // status[2:0]

    // Shadow copy of the stack kept by the predictor.
    logic [DATA_W-1:0] calc_stack [STACK_WORDS];
    int unsigned       calc_count;

    t_calc_result      pending_results [$];
    int                error_count;
    bit                send_calm;
    bit                recv_calm;

    integer_stack_calculator_core #(
        .STACK_DEPTH(STACK_WORDS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Apply one operation to the shadow stack and return what the block must report.
    function automatic t_calc_result apply_op(t_op op, logic [DATA_W-1:0] word,
                                              logic [IDX_W-1:0] idx);
        t_calc_result      res;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        longint            num;
        longint            den;
        longint            quo;
        longint            rem;
        res.value  = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (calc_count >= STACK_WORDS) begin
                    res.status = ST_FULL;
                end else begin
                    calc_stack[calc_count] = word;
                    calc_count++;
                end
            end
            OP_POP: begin
                if (calc_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    calc_count--;
                    res.value = calc_stack[calc_count];
                end
            end
            OP_PEEK_BOTTOM: begin
                if (idx >= calc_count) res.status = ST_RANGE;
                else res.value = calc_stack[idx];
            end
            OP_PEEK_TOP: begin
                if (idx >= calc_count) res.status = ST_RANGE;
                else res.value = calc_stack[calc_count - 1 - idx];
            end
            default: begin
                if (calc_count < 2) begin
                    res.status = ST_FEW;
                end else begin
                    // The top entry is the right-hand operand.
                    rhs = calc_stack[calc_count - 1];
                    lhs = calc_stack[calc_count - 2];
                    calc_count -= 2;
                    case (op)
                        OP_ADD: res.value = lhs + rhs;
                        OP_SUB: res.value = lhs - rhs;
                        OP_MUL: res.value = lhs * rhs;
                        default: begin
                            if (rhs == '0) begin
                                res.status = ST_DIVZERO;
                            end else begin
                                // Truncating divide, then step down when the
                                // remainder's sign differs from the divisor's.
                                num = longint'($signed(lhs));
                                den = longint'($signed(rhs));
                                quo = num / den;
                                rem = num % den;
                                if (rem != 0 && ((rem < 0) != (den < 0))) quo = quo - 1;
                                res.value = quo[DATA_W-1:0];
                            end
                        end
                    endcase
                    if (res.status == ST_OK) begin
                        calc_stack[calc_count] = res.value;
                        calc_count++;
                    end
                end
            end
        endcase
        res.depth = calc_count[DEPTH_W-1:0];
        return res;
    endfunction

    // Offer one operation, wait for its transaction and queue its result.
    task automatic send_op(t_op op, logic [DATA_W-1:0] word, logic [IDX_W-1:0] idx,
                           logic has_want, t_calc_result want);
        int           gap;
        t_calc_result predicted;
        gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W - IDX_W - DATA_W){1'b0}}, idx, word};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = apply_op(op, word, idx);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    // Draw one operation with the given mix and random content.
    task automatic send_random(int push_w, int pop_w, int peek_w, int arith_w);
        int                pick;
        t_op               op;
        logic [DATA_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        pick = $urandom_range(0, push_w + pop_w + peek_w + arith_w - 1);
        if (pick < push_w) op = OP_PUSH;
        else if (pick < push_w + pop_w) op = OP_POP;
        else if (pick < push_w + pop_w + peek_w)
            op = ($urandom_range(0, 1) != 0) ? OP_PEEK_TOP : OP_PEEK_BOTTOM;
        else op = t_op'($urandom_range(OP_ADD, OP_DIV));

        // Favor extremes, zero and small signed words so division cases show up.
        case ($urandom_range(0, 9))
            0: word = 32'h8000_0000;
            1: word = 32'h7FFF_FFFF;
            2: word = 32'hFFFF_FFFF;
            3: word = '0;
            4, 5, 6: word = $urandom_range(0, 40) - 20;
            7: word = $urandom_range(1, 1000);
            default: word = $urandom;
        endcase

        // Mostly in-range indexes, some just past the top, the rest anywhere.
        pick = $urandom_range(0, 7);
        if (calc_count > 0 && pick < 6) idx = IDX_W'($urandom_range(0, calc_count - 1));
        else if (calc_count < STACK_WORDS && pick == 6) idx = IDX_W'(calc_count);
        else idx = IDX_W'($urandom_range(0, STACK_WORDS - 1));

        send_op(op, word, idx, 1'b0, '0);
    endtask

    // Result side: random stalls, with calm stretches where tready stays high.
    initial begin : result_sink
        int gap;
        i_m_axis_tready <= 1'b0;
        forever begin
            gap = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Compare every result transaction against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_calc_result got;
        t_calc_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.value  = o_m_axis_tdata[DATA_W-1:0];
            got.depth  = o_m_axis_tdata[DATA_W +: DEPTH_W];
            got.status = t_status'(o_m_axis_tuser);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, got value %h status %0d depth %0d",
                         $realtime, got.value, got.status, got.depth);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: value mismatch, expected %h, got %h",
                             $realtime, want.value, got.value);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $realtime, want.status, got.status);
                    error_count++;
                end
                if (got.depth !== want.depth) begin
                    $display("%0t: depth mismatch, expected %0d, got %0d",
                             $realtime, want.depth, got.depth);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial begin : stimulus
        int n;
        calc_count      = 0;
        error_count     = 0;
        send_calm       = 1'b0;
        recv_calm       = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_PUSH;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            send_op(DIRECTED[n].op, DIRECTED[n].word, DIRECTED[n].idx,
                    DIRECTED[n].has_want, DIRECTED[n].want);
        end

        // Shallow stack: balanced mix, errors come up often near empty.
        for (n = 0; n < MIXED_ITEMS; n++) send_random(40, 10, 15, 35);

        // Fill to the top with almost only pushes.
        while (calc_count < STACK_WORDS) send_random(97, 1, 1, 1);

        // Hover at the top: full pushes and peeks over the whole index range.
        for (n = 0; n < FULL_ITEMS; n++) send_random(45, 15, 20, 20);

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
